// ===== hw/rtl/fstc_pkg.sv =====
package fstc_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned IN_W     = 128;
  localparam int unsigned OUT_W    = 8;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_FORGET = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FILLED   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOSLOT   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_CONFLICT = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD      = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd5;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_FILL,
    WR_STAMP,
    WR_FORGET
  } wr_op_e;

  // request fields and current frame, seen by every cell
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] fmt;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] frame;
  } bcast_t;

  typedef struct packed {
    wr_op_e           op;
    logic [IDX_W-1:0] idx;
  } wr_cmd_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic             match_attr;
    logic             match_cur;
    logic             empty_found;
    logic [IDX_W-1:0] empty_idx;
    logic             pick_found;
    logic [IDX_W-1:0] pick_idx;
    logic [31:0]      best_age;
  } carry_t;

endpackage

// ===== hw/rtl/fstc_cell.sv =====
module fstc_cell
  import fstc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  bcast_t           bcast_i,
  input  wr_cmd_t          wr_i,
  input  carry_t           carry_i,
  output carry_t           carry_o
);

  logic [63:0] key_q;
  logic [31:0] fmt_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [31:0] stamp_q;
  carry_t      carry_q;
  carry_t      carry_d;

  logic        key_eq;
  logic        attr_eq;
  logic        is_cur;
  logic [31:0] age;
  logic        sel;

  assign key_eq  = (key_q == bcast_i.key);
  assign attr_eq = (fmt_q == bcast_i.fmt) && (width_q == bcast_i.width)
                   && (height_q == bcast_i.height);
  assign is_cur  = (stamp_q == bcast_i.frame);
  assign age     = bcast_i.frame - stamp_q;
  assign sel     = (wr_i.idx == idx_i);

  always_comb begin
    carry_d = carry_i;
    if (!carry_i.match_found && key_eq) begin
      carry_d.match_found = 1'b1;
      carry_d.match_idx   = idx_i;
      carry_d.match_attr  = attr_eq;
      carry_d.match_cur   = is_cur;
    end
    if (!carry_i.empty_found && (key_q == 64'd0)) begin
      carry_d.empty_found = 1'b1;
      carry_d.empty_idx   = idx_i;
    end
    if (!is_cur && (age > carry_i.best_age)) begin
      carry_d.pick_found = 1'b1;
      carry_d.pick_idx   = idx_i;
      carry_d.best_age   = age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      fmt_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      stamp_q  <= '0;
      carry_q  <= '0;
    end else begin
      carry_q <= carry_d;
      unique case (wr_i.op)
        WR_FILL: begin
          if (sel) begin
            key_q    <= bcast_i.key;
            fmt_q    <= bcast_i.fmt;
            width_q  <= bcast_i.width;
            height_q <= bcast_i.height;
            stamp_q  <= bcast_i.frame;
          end
        end
        WR_STAMP: begin
          if (sel) begin
            stamp_q <= bcast_i.frame;
          end
        end
        WR_FORGET: begin
          if (key_eq) begin
            key_q    <= '0;
            fmt_q    <= '0;
            width_q  <= '0;
            height_q <= '0;
            stamp_q  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign carry_o = carry_q;

endmodule

// ===== hw/rtl/frame_stamped_target_slot_cache_top.sv =====
// Slot cache of ENTRIES target entries keyed by image identity, with per-frame
// use stamps and oldest-entry replacement. One request per input beat, one
// result beat per request. A request walks the row of entry cells one cell
// per cycle; the next request is taken only once the result is latched for
// output. Entries are cleared by reset, the frame counter starts at one.
module frame_stamped_target_slot_cache_top
  import fstc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // image_key[63:0], format_id[95:64], width[111:96], height[127:112]
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]       s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // status[2:0], slot_index[6:3], replaced[7]
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_e;

  state_e            state_q;
  logic              start_q;
  logic [1:0]        type_q;
  logic [63:0]       req_key_q;
  logic [31:0]       req_fmt_q;
  logic [15:0]       req_width_q;
  logic [15:0]       req_height_q;
  logic [31:0]       frame_q;
  bcast_t            bcast;
  carry_t            res_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  carry_t            chain [ENTRIES+1];
  wr_cmd_t           wr_cmd;
  logic              accept;
  logic              finish;
  logic              lookup_ok;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]  slot;
  logic              repl;

  assign bcast = '{key: req_key_q, fmt: req_fmt_q, width: req_width_q,
                   height: req_height_q, frame: frame_q};

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign finish    = (state_q == S_WAIT) && (!out_valid_q || m_axis_tready_i);
  assign lookup_ok = (bcast.key != 64'd0) && (bcast.width != 16'd0)
                     && (bcast.height != 16'd0);

  assign chain[0] = carry_t'({start_q, {($bits(carry_t)-1){1'b0}}});

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    fstc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(k)),
      .bcast_i (bcast),
      .wr_i    (wr_cmd),
      .carry_i (chain[k]),
      .carry_o (chain[k+1])
    );
  end

  always_comb begin
    status    = STAT_DONE;
    slot      = '0;
    repl      = 1'b0;
    wr_cmd.op = WR_NONE;
    wr_cmd.idx = '0;
    priority if (type_q == REQ_TICK) begin
      status = STAT_DONE;
    end else if (type_q == REQ_FORGET) begin
      status = STAT_DONE;
      if (bcast.key != 64'd0) begin
        wr_cmd.op = WR_FORGET;
      end
    end else if (type_q != REQ_LOOKUP || !lookup_ok) begin
      status = STAT_BAD;
    end else if (res_q.match_found) begin
      if (res_q.match_attr) begin
        status     = STAT_HIT;
        slot       = res_q.match_idx;
        wr_cmd.op  = WR_STAMP;
        wr_cmd.idx = res_q.match_idx;
      end else if (res_q.match_cur) begin
        status = STAT_CONFLICT;
      end else begin
        status     = STAT_FILLED;
        slot       = res_q.match_idx;
        repl       = 1'b1;
        wr_cmd.op  = WR_FILL;
        wr_cmd.idx = res_q.match_idx;
      end
    end else if (res_q.empty_found) begin
      status     = STAT_FILLED;
      slot       = res_q.empty_idx;
      wr_cmd.op  = WR_FILL;
      wr_cmd.idx = res_q.empty_idx;
    end else if (res_q.pick_found) begin
      status     = STAT_FILLED;
      slot       = res_q.pick_idx;
      repl       = 1'b1;
      wr_cmd.op  = WR_FILL;
      wr_cmd.idx = res_q.pick_idx;
    end else begin
      status = STAT_NOSLOT;
    end
    if (!finish) begin
      wr_cmd.op = WR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      frame_q     <= 32'd1;
    end else begin
      start_q     <= accept;
      out_valid_q <= finish || (out_valid_q && !m_axis_tready_i);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[ENTRIES].valid) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (finish) begin
            state_q <= S_IDLE;
            if (type_q == REQ_TICK) begin
              frame_q <= frame_q + 32'd1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q       <= s_axis_tuser_i;
      req_key_q    <= s_axis_tdata_i[63:0];
      req_fmt_q    <= s_axis_tdata_i[95:64];
      req_width_q  <= s_axis_tdata_i[111:96];
      req_height_q <= s_axis_tdata_i[127:112];
    end
    if (state_q == S_SCAN && chain[ENTRIES].valid) begin
      res_q <= chain[ENTRIES];
    end
    if (finish) begin
      out_data_q <= {repl, SLOT_W'(slot), status};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_scan_end_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[ENTRIES].valid |-> (state_q == S_SCAN))
    else $error("scan result arrived outside scan");

  a_frame_on_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(frame_q) |-> $past(finish && (type_q == REQ_TICK)))
    else $error("frame counter moved without a tick");

  a_no_lost_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid_o)
    else $error("finished request produced no result beat");

endmodule

// ===== tb/sv/tb_frame_stamped_target_slot_cache_top.sv =====
module tb_frame_stamped_target_slot_cache_top
  import fstc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  class slot_cache_scoreboard;

    typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                replaced;
    } outcome_t;

    bit [63:0] slot_key    [ENTRIES];
    bit [31:0] slot_format [ENTRIES];
    bit [15:0] slot_width  [ENTRIES];
    bit [15:0] slot_height [ENTRIES];
    bit [31:0] slot_stamp  [ENTRIES];
    bit [31:0] frame_no;

    outcome_t    pending_outcomes[$];
    int unsigned errors;
    int unsigned status_seen[8];
    int unsigned evictions;

    function new();
      frame_no = 32'd1;
    endfunction

    // advance the slot table by one accepted request and queue its outcome
    function void note_request(logic [1:0] user, logic [IN_W-1:0] beat);
      logic [1:0]  req;
      logic [63:0] key;
      logic [31:0] fmt;
      logic [15:0] w;
      logic [15:0] h;
      outcome_t    o;
      int          pick;
      int          fill_at;
      bit [31:0]   best;
      bit [31:0]   age;
      req = user;
      key = beat[63:0];
      fmt = beat[95:64];
      w   = beat[111:96];
      h   = beat[127:112];
      o.status   = STAT_DONE;
      o.slot     = '0;
      o.replaced = 1'b0;
      fill_at    = -1;
      if (req == REQ_TICK) begin
        frame_no = frame_no + 32'd1;
      end else if (req == REQ_FORGET) begin
        if (key != 64'd0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_key[i] == key) begin
              slot_key[i]    = '0;
              slot_format[i] = '0;
              slot_width[i]  = '0;
              slot_height[i] = '0;
              slot_stamp[i]  = '0;
            end
          end
        end
      end else if (req != REQ_LOOKUP || key == 64'd0 || w == 16'd0 || h == 16'd0) begin
        o.status = STAT_BAD;
      end else begin
        pick = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (pick < 0 && slot_key[i] == key) pick = i;
        end
        if (pick >= 0) begin
          if (slot_format[pick] == fmt && slot_width[pick] == w
              && slot_height[pick] == h) begin
            slot_stamp[pick] = frame_no;
            o.status = STAT_HIT;
            o.slot   = SLOT_W'(pick);
          end else if (slot_stamp[pick] == frame_no) begin
            o.status = STAT_CONFLICT;
          end else begin
            fill_at    = pick;
            o.replaced = 1'b1;
          end
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (pick < 0 && slot_key[i] == 64'd0) pick = i;
          end
          if (pick < 0) begin
            // oldest entry not touched this frame, lowest index on a tie
            best = '0;
            for (int i = 0; i < ENTRIES; i++) begin
              age = frame_no - slot_stamp[i];
              if (slot_stamp[i] != frame_no && age > best) begin
                best = age;
                pick = i;
              end
            end
            o.replaced = (pick >= 0);
          end
          if (pick < 0) o.status = STAT_NOSLOT;
          else fill_at = pick;
        end
        if (fill_at >= 0) begin
          slot_key[fill_at]    = key;
          slot_format[fill_at] = fmt;
          slot_width[fill_at]  = w;
          slot_height[fill_at] = h;
          slot_stamp[fill_at]  = frame_no;
          o.status = STAT_FILLED;
          o.slot   = SLOT_W'(fill_at);
        end
      end
      pending_outcomes.push_back(o);
      status_seen[o.status]++;
      if (o.replaced) evictions++;
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      outcome_t exp_o;
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat %h with no request pending", beat);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (beat[2:0] !== exp_o.status || beat[6:3] !== exp_o.slot
            || beat[7] !== exp_o.replaced) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d slot %0d replaced %0d, got %0d %0d %0d",
                     exp_o.status, exp_o.slot, exp_o.replaced,
                     beat[2:0], beat[6:3], beat[7]);
        end
      end
    endfunction
  endclass

  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned KEY_POOL    = 20;
  localparam int unsigned PHASE_ITEMS = 217;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned QUIET_LIMIT = 4000;

  logic            clk     = 1'b0;
  logic            rst_n   = 1'b0;
  logic            s_valid = 1'b0;
  logic [IN_W-1:0] s_data  = '0;
  logic [1:0]      s_user  = '0;
  logic            m_ready = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;

  slot_cache_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned tick_pct      = 10;
  bit          long_hold_req = 1'b0;
  int unsigned quiet_cycles  = 0;
  logic [63:0] key_pool [KEY_POOL];
  logic [31:0] fmt_pool [4];
  logic [15:0] w_pool   [4];
  logic [15:0] h_pool   [4];

  frame_stamped_target_slot_cache_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk = ~clk;

  // handshakes are sampled at the falling edge, where every signal is settled
  always @(negedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o);
      if (s_valid && s_axis_tready_o) sb.note_request(s_user, s_data);
      if ((m_axis_tvalid_o && m_ready) || (s_valid && s_axis_tready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    bit          ready_next;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        ready_next = 1'b0;
        hold_left--;
      end else begin
        ready_next = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      m_ready <= ready_next;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [63:0] key,
                              input logic [31:0] fmt, input logic [15:0] w,
                              input logic [15:0] h);
    bit accepted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {h, w, fmt, key};
    s_user  <= req;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = s_axis_tready_o;
      @(posedge clk);
    end
  endtask

  task automatic random_request();
    int unsigned r;
    int unsigned k;
    int unsigned alt;
    logic [1:0]  req;
    logic [63:0] key;
    logic [31:0] fmt;
    logic [15:0] w;
    logic [15:0] h;
    r   = $urandom_range(99);
    k   = $urandom_range(KEY_POOL - 1);
    alt = ($urandom_range(3) == 0);
    key = key_pool[k];
    fmt = fmt_pool[(k + alt) % 4];
    w   = w_pool[(k + alt) % 4];
    h   = h_pool[(k + 2 * alt) % 4];
    if ($urandom_range(19) == 0) begin
      key = {$urandom, $urandom};
      fmt = $urandom;
      w   = 16'($urandom);
      h   = 16'($urandom);
    end
    if (r < tick_pct) begin
      req = REQ_TICK;
    end else if (r < tick_pct + 8) begin
      req = REQ_FORGET;
      if ($urandom_range(9) == 0) key = '0;
    end else if (r < tick_pct + 10) begin
      req = REQ_UNUSED;
    end else begin
      req = REQ_LOOKUP;
      if (r < tick_pct + 14) begin
        case ($urandom_range(2))
          0: key = '0;
          1: w = '0;
          default: h = '0;
        endcase
      end
    end
    send_request(req, key, fmt, w, h);
  endtask

  initial begin
    sb = new();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom} | 64'd1;
    key_pool[0] = '1;
    fmt_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    w_pool   = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)), 16'd640};
    h_pool   = '{16'hFFFF, 16'd1, 16'($urandom_range(1, 65535)), 16'd480};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 46;
    // malformed requests and empty forgets
    send_request(REQ_LOOKUP, 64'd0, 32'd7, 16'd8, 16'd8);
    send_request(REQ_LOOKUP, 64'h55, 32'd7, 16'd0, 16'd8);
    send_request(REQ_LOOKUP, 64'h55, 32'd7, 16'd8, 16'd0);
    send_request(REQ_UNUSED, 64'h55, 32'd7, 16'd8, 16'd8);
    send_request(REQ_FORGET, 64'd0, 32'd0, 16'd0, 16'd0);
    send_request(REQ_FORGET, 64'h1234, 32'd0, 16'd0, 16'd0);
    // fill, hit, same-frame conflict, refill in the next frame
    send_request(REQ_LOOKUP, 64'hA, 32'd7, 16'd64, 16'd32);
    send_request(REQ_LOOKUP, 64'hA, 32'd7, 16'd64, 16'd32);
    send_request(REQ_LOOKUP, 64'hA, 32'd9, 16'd64, 16'd32);
    send_request(REQ_TICK, 64'd0, 32'd0, 16'd0, 16'd0);
    send_request(REQ_LOOKUP, 64'hA, 32'd9, 16'd64, 16'd32);
    // field extremes
    send_request(REQ_LOOKUP, '1, '1, '1, '1);
    send_request(REQ_LOOKUP, 64'd1, 32'd0, 16'd1, 16'd1);
    send_request(REQ_LOOKUP, '1, '1, '1, '1);
    // forget frees slot 0, next absent key lands there
    send_request(REQ_FORGET, 64'hA, 32'd0, 16'd0, 16'd0);
    send_request(REQ_LOOKUP, 64'hC, 32'd3, 16'd16, 16'd16);
    send_request(REQ_TICK, '1, '1, '1, '1);
    send_request(REQ_LOOKUP, 64'd1, 32'd5, 16'd1, 16'd1);
    send_request(REQ_LOOKUP, 64'd1, 32'd5, 16'd1, 16'd1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 46 : 0;
      recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 25 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          case ($urandom_range(2))
            0: tick_pct = 2;
            1: tick_pct = 10;
            default: tick_pct = 30;
          endcase
        end
        if (n == 100 && ph != 1) long_hold_req = 1'b1;
        random_request();
      end
    end
    s_valid <= 1'b0;

    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending_outcomes.size() != 0) sb.errors++;

    $display("Requests: %0d hits, %0d fills (%0d evicting a live entry), %0d no-slot, %0d conflicts",
             sb.status_seen[STAT_HIT], sb.status_seen[STAT_FILLED], sb.evictions,
             sb.status_seen[STAT_NOSLOT], sb.status_seen[STAT_CONFLICT]);
    $display("Plus %0d malformed and %0d ticks/forgets, under both stall mixes and a long hold",
             sb.status_seen[STAT_BAD], sb.status_seen[STAT_DONE]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
